>>> hw/rtl/usart_register_model_macros.svh
// assertion helpers for the usart register model
`ifndef USART_REGISTER_MODEL_MACROS_SVH
`define USART_REGISTER_MODEL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define USART_RM_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("usart_register_model: check failed");
`define USART_RM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("usart_register_model: sequence check failed");
`else
`define USART_RM_ASSERT(label, cond)
`define USART_RM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/usart_rm_pkg.sv
`default_nettype none
package usart_rm_pkg;

  typedef enum logic [2:0] {
    MODE_RESET      = 3'd0,
    MODE_CTRL_WR    = 3'd1,
    MODE_DATA_WR    = 3'd2,
    MODE_STATUS_RD  = 3'd3,
    MODE_DATA_RD    = 3'd4,
    MODE_SERIAL_RX  = 3'd5,
    MODE_HOST_PUSH  = 3'd6,
    MODE_HOST_READ  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    CFG_HOST_ENABLED = 2'd0,
    CFG_TAPE_PRESENT = 2'd1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic pump;
    logic pop;
    logic emit;
    logic last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pump_req;
    logic pop_start;
    logic pop_last;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/usart_rm_ctrl.sv
`default_nettype none
module usart_rm_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire usart_rm_pkg::dp_sts_t sts_i,
  output usart_rm_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PREP,
    ST_PUMP,
    ST_POP_RD,
    ST_POP,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   last_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.pump = (state_q == ST_PUMP);
    cmd_o.pop  = (state_q == ST_POP);
    cmd_o.emit = (state_q == ST_EMIT) && slot_free;
    cmd_o.last = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= 1'b1;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          priority if (sts_i.pop_start) begin
            state_q <= ST_POP_RD;
          end else if (sts_i.pump_req) begin
            state_q <= ST_PREP;
          end else begin
            state_q <= ST_EMIT;
            last_q  <= 1'b1;
          end
        end
        ST_PREP: state_q <= ST_PUMP;
        ST_PUMP: begin
          state_q <= ST_EMIT;
          last_q  <= 1'b1;
        end
        ST_POP_RD: state_q <= ST_POP;
        ST_POP: begin
          if (sts_i.pop_last) begin
            state_q <= ST_PREP;
          end else begin
            state_q <= ST_EMIT;
            last_q  <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (slot_free) state_q <= last_q ? ST_IDLE : ST_POP_RD;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/usart_rm_dp.sv
`default_nettype none
module usart_rm_dp #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire usart_rm_pkg::dp_cmd_t cmd_i,
  output usart_rm_pkg::dp_sts_t      sts_o,
  input  wire logic [2:0]            mode_i,
  input  wire logic [7:0]            value_i,
  input  wire logic [6:0]            count_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic                  cfg_data_i,
  output logic [7:0]                 read_data_o,
  output logic                       read_valid_o,
  output logic                       rx_ready_irq_o,
  output logic                       request_release_o,
  output logic                       tape_write_o,
  output logic [7:0]                 tape_data_o,
  output logic                       tape_serial_on_o,
  output logic [7:0]                 tape_format_o,
  output logic                       write_accepted_o,
  output logic [6:0]                 rx_free_slots_o,
  output logic                       last_o
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = AW + 2;

  localparam logic [7:0] ST_TXRDY = 8'h01;
  localparam logic [7:0] ST_RXRDY = 8'h02;
  localparam logic [7:0] ST_TXE   = 8'h04;
  localparam logic [7:0] ST_ERR   = 8'h38;
  localparam logic [7:0] ST_OE    = 8'h10;
  localparam logic [7:0] ST_DSR   = 8'h80;
  localparam logic [7:0] CLR_MASK = 8'h92;
  localparam logic [7:0] FMT_RST  = 8'hcc;
  localparam logic [7:0] FMT_M1   = 8'hfc;
  localparam logic [7:0] FMT_M0   = 8'hdc;

  typedef enum logic [2:0] {
    PH_CLEAR = 3'd0,
    PH_ASYNC = 3'd1,
    PH_SYNC1 = 3'd2,
    PH_SYNC2 = 3'd3,
    PH_SYNC  = 3'd4
  } phase_e;

  usart_rm_pkg::mode_e mode_q;
  logic [7:0]          value_q;
  logic [6:0]          count_q;
  logic                host_en_q, tape_q;
  phase_e              phase_q;
  logic                rx_en_q, tx_en_q;
  logic [3:0]          char_len_q;
  logic [7:0]          status_q, rx_data_q, fmt_q;
  logic [AW-1:0]       in_head_q, out_head_q;
  logic [CW-1:0]       in_cnt_q, out_cnt_q;
  logic                ser_on_q;
  logic [7:0]          ser_fmt_q;
  logic                irq_q, rel_q, tw_q, acc_q, rdv_q;
  logic [7:0]          td_q, rd_q;
  logic [6:0]          remain_q;
  logic [7:0]          in_rdata_q, out_rdata_q;
  logic [7:0]          in_mem  [FIFO_DEPTH];
  logic [7:0]          out_mem [FIFO_DEPTH];

  logic [7:0]    char_mask, masked_val, pump_status;
  logic          in_full, out_full, pump_take, in_we, out_we;
  logic [SW-1:0] in_sum, out_sum;
  logic [AW-1:0] in_waddr, out_waddr;
  logic [6:0]    out_cnt7, pop_n;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] h);
    return (h == AW'(FIFO_DEPTH - 1)) ? '0 : h + AW'(1);
  endfunction

  function automatic logic [7:0] clr_status(input logic [7:0] s, input logic h);
    return (s & ~CLR_MASK) | ST_TXRDY | ST_TXE | (h ? ST_DSR : 8'h00);
  endfunction

  always_comb begin
    char_mask  = (char_len_q[2:0] == 3'd0) ? 8'hff
               : 8'((9'd1 << char_len_q[2:0]) - 9'd1);
    masked_val = value_q & char_mask;
    in_full    = (in_cnt_q == CW'(FIFO_DEPTH));
    out_full   = (out_cnt_q == CW'(FIFO_DEPTH));
    in_sum     = SW'(in_head_q) + SW'(in_cnt_q);
    if (in_sum >= SW'(FIFO_DEPTH)) in_sum = in_sum - SW'(FIFO_DEPTH);
    out_sum    = SW'(out_head_q) + SW'(out_cnt_q);
    if (out_sum >= SW'(FIFO_DEPTH)) out_sum = out_sum - SW'(FIFO_DEPTH);
    in_waddr   = in_sum[AW-1:0];
    out_waddr  = out_sum[AW-1:0];
    out_cnt7   = 7'(out_cnt_q);
    pop_n      = (count_q < out_cnt7) ? count_q : out_cnt7;
    in_we      = cmd_i.exec && (mode_q == usart_rm_pkg::MODE_HOST_PUSH)
               && host_en_q && !in_full;
    out_we     = cmd_i.exec && (mode_q == usart_rm_pkg::MODE_DATA_WR)
               && tx_en_q && host_en_q && !out_full;
    // transmit flags follow the output queue, receive side refills from the input queue
    pump_take   = rx_en_q && !status_q[1] && (in_cnt_q != '0);
    pump_status = status_q & ~(ST_TXRDY | ST_TXE);
    if (!out_full) pump_status = pump_status | ST_TXRDY;
    if (out_cnt_q == '0) pump_status = pump_status | ST_TXE;
    if (pump_take) pump_status = pump_status | ST_RXRDY;
  end

  always_comb begin
    sts_o = '0;
    unique case (mode_q)
      usart_rm_pkg::MODE_CTRL_WR:
        sts_o.pump_req = host_en_q && !value_q[6]
                       && (phase_q == PH_ASYNC || phase_q == PH_SYNC);
      usart_rm_pkg::MODE_DATA_WR:   sts_o.pump_req = tx_en_q && host_en_q;
      usart_rm_pkg::MODE_STATUS_RD: sts_o.pump_req = host_en_q;
      usart_rm_pkg::MODE_DATA_RD:   sts_o.pump_req = host_en_q;
      usart_rm_pkg::MODE_HOST_PUSH: sts_o.pump_req = host_en_q && !in_full;
      usart_rm_pkg::MODE_HOST_READ: sts_o.pump_req = host_en_q && (pop_n == 7'd0);
      default:                      sts_o.pump_req = 1'b0;
    endcase
    sts_o.pop_start = (mode_q == usart_rm_pkg::MODE_HOST_READ) && host_en_q
                    && (pop_n != 7'd0);
    sts_o.pop_last  = (remain_q == 7'd1);
  end

  always_ff @(posedge clk_i) begin
    if (in_we) in_mem[in_waddr] <= value_q;
    if (out_we) out_mem[out_waddr] <= masked_val;
    in_rdata_q  <= in_mem[in_head_q];
    out_rdata_q <= out_mem[out_head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= usart_rm_pkg::MODE_RESET;
      value_q    <= '0;
      count_q    <= '0;
      host_en_q  <= 1'b0;
      tape_q     <= 1'b1;
      phase_q    <= PH_CLEAR;
      rx_en_q    <= 1'b0;
      tx_en_q    <= 1'b0;
      char_len_q <= 4'd8;
      status_q   <= ST_TXRDY | ST_TXE;
      rx_data_q  <= '0;
      fmt_q      <= FMT_RST;
      in_head_q  <= '0;
      in_cnt_q   <= '0;
      out_head_q <= '0;
      out_cnt_q  <= '0;
      ser_on_q   <= 1'b0;
      ser_fmt_q  <= FMT_RST;
      irq_q      <= 1'b0;
      rel_q      <= 1'b0;
      tw_q       <= 1'b0;
      td_q       <= '0;
      acc_q      <= 1'b0;
      rd_q       <= '0;
      rdv_q      <= 1'b0;
      remain_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == usart_rm_pkg::CFG_HOST_ENABLED) begin
          if (cfg_data_i != host_en_q) begin
            host_en_q  <= cfg_data_i;
            in_head_q  <= '0;
            in_cnt_q   <= '0;
            out_head_q <= '0;
            out_cnt_q  <= '0;
            rx_data_q  <= '0;
            status_q   <= clr_status(status_q, cfg_data_i);
            if (tape_q) begin
              ser_on_q  <= tx_en_q && !cfg_data_i;
              ser_fmt_q <= fmt_q;
            end
          end
        end else if (cfg_index_i == usart_rm_pkg::CFG_TAPE_PRESENT) begin
          tape_q <= cfg_data_i;
        end
      end

      if (cmd_i.load) begin
        mode_q  <= usart_rm_pkg::mode_e'(mode_i);
        value_q <= value_i;
        count_q <= count_i;
        irq_q   <= 1'b0;
        rel_q   <= 1'b0;
        tw_q    <= 1'b0;
        td_q    <= '0;
        acc_q   <= 1'b0;
        rd_q    <= '0;
        rdv_q   <= 1'b0;
      end

      if (cmd_i.exec) begin
        unique case (mode_q)
          usart_rm_pkg::MODE_RESET: begin
            rx_en_q    <= 1'b0;
            tx_en_q    <= 1'b0;
            char_len_q <= 4'd8;
            rx_data_q  <= '0;
            fmt_q      <= FMT_RST;
            phase_q    <= PH_CLEAR;
            in_head_q  <= '0;
            in_cnt_q   <= '0;
            out_head_q <= '0;
            out_cnt_q  <= '0;
            status_q   <= ST_TXRDY | ST_TXE | (host_en_q ? ST_DSR : 8'h00);
            if (tape_q) begin
              ser_on_q  <= 1'b0;
              ser_fmt_q <= FMT_RST;
            end
          end
          usart_rm_pkg::MODE_CTRL_WR: begin
            unique case (phase_q)
              PH_CLEAR: begin
                fmt_q <= value_q & (value_q[4] ? FMT_M1 : FMT_M0);
                if (value_q[1:0] != 2'b00) begin
                  phase_q    <= PH_ASYNC;
                  char_len_q <= 4'd5 + {2'b00, value_q[3:2]};
                end else begin
                  phase_q <= PH_SYNC1;
                end
              end
              PH_SYNC1: phase_q <= PH_SYNC2;
              PH_SYNC2: phase_q <= PH_SYNC;
              PH_ASYNC, PH_SYNC: begin
                if (value_q[6]) begin
                  // internal reset command
                  phase_q <= PH_CLEAR;
                  rx_en_q <= 1'b0;
                  tx_en_q <= 1'b0;
                  if (host_en_q) begin
                    in_head_q  <= '0;
                    in_cnt_q   <= '0;
                    out_head_q <= '0;
                    out_cnt_q  <= '0;
                    rx_data_q  <= '0;
                    status_q   <= clr_status(status_q, 1'b1);
                  end
                  if (tape_q) begin
                    ser_on_q  <= 1'b0;
                    ser_fmt_q <= fmt_q;
                  end
                end else begin
                  if (value_q[4]) status_q <= status_q & ~ST_ERR;
                  rx_en_q <= value_q[2];
                  tx_en_q <= value_q[0];
                  if (tape_q) begin
                    ser_on_q  <= value_q[0] && !host_en_q;
                    ser_fmt_q <= fmt_q;
                  end
                end
              end
              default: ;
            endcase
          end
          usart_rm_pkg::MODE_DATA_WR: begin
            if (tx_en_q) begin
              if (host_en_q) begin
                if (!out_full) begin
                  out_cnt_q <= out_cnt_q + CW'(1);
                  acc_q     <= 1'b1;
                end
              end else if (tape_q) begin
                tw_q  <= 1'b1;
                td_q  <= masked_val;
                acc_q <= 1'b1;
              end
            end
          end
          usart_rm_pkg::MODE_STATUS_RD: rdv_q <= 1'b1;
          usart_rm_pkg::MODE_DATA_RD: begin
            status_q <= status_q & ~ST_RXRDY;
            rd_q     <= rx_data_q;
            rdv_q    <= 1'b1;
            if (!host_en_q && status_q[1]) rel_q <= 1'b1;
          end
          usart_rm_pkg::MODE_SERIAL_RX: begin
            if (!host_en_q && rx_en_q) begin
              rx_data_q <= value_q;
              status_q  <= status_q | ST_RXRDY | (status_q[1] ? ST_OE : 8'h00);
              irq_q     <= 1'b1;
            end
          end
          usart_rm_pkg::MODE_HOST_PUSH: begin
            if (host_en_q && !in_full) begin
              in_cnt_q <= in_cnt_q + CW'(1);
              acc_q    <= 1'b1;
            end
          end
          usart_rm_pkg::MODE_HOST_READ: remain_q <= pop_n;
          default: ;
        endcase
      end

      if (cmd_i.pump) begin
        status_q <= pump_status;
        if (pump_take) begin
          rx_data_q <= in_rdata_q & char_mask;
          in_head_q <= wrap_inc(in_head_q);
          in_cnt_q  <= in_cnt_q - CW'(1);
          irq_q     <= 1'b1;
        end
      end

      if (cmd_i.pop) begin
        rd_q       <= out_rdata_q;
        rdv_q      <= 1'b1;
        out_head_q <= wrap_inc(out_head_q);
        out_cnt_q  <= out_cnt_q - CW'(1);
        remain_q   <= remain_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      read_data_o       <= (mode_q == usart_rm_pkg::MODE_STATUS_RD) ? status_q : rd_q;
      read_valid_o      <= rdv_q;
      rx_ready_irq_o    <= irq_q;
      request_release_o <= rel_q;
      tape_write_o      <= tw_q;
      tape_data_o       <= td_q;
      tape_serial_on_o  <= ser_on_q;
      tape_format_o     <= ser_fmt_q;
      write_accepted_o  <= acc_q;
      rx_free_slots_o   <= 7'(FIFO_DEPTH) - 7'(in_cnt_q);
      last_o            <= cmd_i.last;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/usart_register_model.sv
// 8251-style usart register model. each bus access (reset, control write, data write,
// status read, data read, serial receive, host push, host read) is one input
// transaction and yields one result transaction, except a host read, which yields one
// result per popped byte with last marking the final one. an access steps through its
// execute and result handover states; when the host queues are serviced, a prepare and
// a pump state come between the two (the host fifos return registered read data, so
// the receive side refills only after the prepare state). a host read runs a read and a
// pop state per byte, and its final byte also passes prepare and pump. each result
// handover may wait on the sink, which holds the block in its handover state. the
// next access is taken once the current one has handed over its final result; the
// result register holds it until the sink takes it. configuration writes are taken
// at any time on their own channel and must only come while the block is idle.
// fifo depth is set by FIFO_DEPTH (2 to 64); fifo contents need no clearing after reset.
`default_nettype none
`include "usart_register_model_macros.svh"
module usart_register_model #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // access channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [2:0] mode_i,
  input  wire logic [7:0] value_i,
  input  wire logic [6:0] count_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o,
  output logic            read_valid_o,
  output logic            rx_ready_irq_o,
  output logic            request_release_o,
  output logic            tape_write_o,
  output logic [7:0]      tape_data_o,
  output logic            tape_serial_on_o,
  output logic [7:0]      tape_format_o,
  output logic            write_accepted_o,
  output logic [6:0]      rx_free_slots_o,
  output logic            last_o,
  // configuration channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic       cfg_data_i
);

  usart_rm_pkg::dp_cmd_t cmd;
  usart_rm_pkg::dp_sts_t sts;

  // register writes are always accepted
  assign cfg_ready_o = 1'b1;

  // sequencer: accept, execute, optional queue service, pop loop, result handover
  usart_rm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // register file, host fifos and result register
  usart_rm_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (mode_i),
    .value_i           (value_i),
    .count_i           (count_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .read_data_o       (read_data_o),
    .read_valid_o      (read_valid_o),
    .rx_ready_irq_o    (rx_ready_irq_o),
    .request_release_o (request_release_o),
    .tape_write_o      (tape_write_o),
    .tape_data_o       (tape_data_o),
    .tape_serial_on_o  (tape_serial_on_o),
    .tape_format_o     (tape_format_o),
    .write_accepted_o  (write_accepted_o),
    .rx_free_slots_o   (rx_free_slots_o),
    .last_o            (last_o)
  );

  // busy right after taking an access
  `USART_RM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  // free slot count never exceeds the fifo depth
  `USART_RM_ASSERT(a_free_slots_range, !out_valid_o || rx_free_slots_o <= 7'(FIFO_DEPTH))
  // read data is zero unless flagged meaningful
  `USART_RM_ASSERT(a_read_data_zero, !out_valid_o || read_valid_o || read_data_o == 8'h00)
  // tape byte is zero unless a tape write happened
  `USART_RM_ASSERT(a_tape_data_zero, !out_valid_o || tape_write_o || tape_data_o == 8'h00)

endmodule
`default_nettype wire
